/* src/sktab_pkg.sv */
`timescale 1ns / 1ps

package sktab_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 16;
    localparam int NAME_BYTES  = 8;

    // Fixed field widths.
    localparam int SCORE_W   = 32;
    localparam int NAME_W    = 64;
    localparam int ENTRIES_W = 5;
    localparam int NLEN_W    = 4;
    localparam int RIDX_W    = 4;
    localparam int PLACED_W  = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 5;

    // Derived widths: a cell position and a count that can hold TABLE_DEPTH itself.
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_LEN = 1'd1;

    typedef enum logic [1:0] {
        MODE_INSERT   = 2'd0,
        MODE_READ_IDX = 2'd1,
        MODE_READ_LOW = 2'd2,
        MODE_NONE     = 2'd3
    } t_mode;

    // Values broadcast from the top level to every cell.
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [NAME_W-1:0]         name;
        logic [CNT_W-1:0]          count;
    } t_bcast;

    // Keeps the first len bytes of a name, clearing the rest.
    function automatic logic [NAME_W-1:0] name_mask(input logic [NLEN_W-1:0] len);
        logic [NAME_W-1:0] mask;
        mask = '0;
        for (int b = 0; b < NAME_W / 8; b++) begin
            if ((b < NAME_BYTES) && (b < int'(len))) begin
                mask[b*8 +: 8] = 8'hFF;
            end
        end
        return mask;
    endfunction

endpackage

/* src/sktab_cell.sv */
`timescale 1ns / 1ps

module sktab_cell
    import sktab_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [IDX_W-1:0]          i_cell_idx,
    input  t_bcast                    i_bcast,
    input  logic                      i_commit,
    input  logic                      i_found,
    input  logic signed [SCORE_W-1:0] i_prev_score,
    input  logic [NAME_W-1:0]         i_prev_name,
    output logic                      o_found,
    output logic                      o_here,
    output logic signed [SCORE_W-1:0] o_score,
    output logic [NAME_W-1:0]         o_name
);

    logic signed [SCORE_W-1:0] r_score;
    logic signed [SCORE_W-1:0] n_score;
    logic [NAME_W-1:0]         r_name;
    logic [NAME_W-1:0]         n_name;
    logic                      w_live;
    logic                      w_hit;

    // A live cell is a candidate when its score is not above the new one.
    assign w_live  = {{(CNT_W-IDX_W){1'b0}}, i_cell_idx} < i_bcast.count;
    assign w_hit   = w_live && !(r_score > i_bcast.score);
    assign o_found = i_found || w_hit;
    assign o_here  = w_hit && !i_found;
    assign o_score = r_score;
    assign o_name  = r_name;

    always_comb begin
        n_score = r_score;
        n_name  = r_name;
        if (i_commit && w_live) begin
            if (i_found) begin
                n_score = i_prev_score;
                n_name  = i_prev_name;
            end else if (w_hit) begin
                n_score = i_bcast.score;
                n_name  = i_bcast.name;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score <= '0;
            r_name  <= '0;
        end else begin
            r_score <= n_score;
            r_name  <= n_name;
        end
    end

endmodule

/* src/sorted_top_k_score_table.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_stall     i_mode, i_new_score, i_new_name, i_read_index
// output    out        o_out_valid / i_out_stall   o_placed_at, o_entry_score, o_entry_name,
//                                                  o_bad_index
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// Each word is accepted at one edge, and its result word is written to the output register
// at that same edge; the compare across the row of cells is combinational.
// Reset is synchronous and active low; it clears every cell to a zero score and an empty
// name and restores the register defaults, so no clearing pass is needed.
// The input stalls only while a result word is held and the output side stalls.

module sorted_top_k_score_table
    import sktab_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_mode,
    input  logic signed [SCORE_W-1:0] i_new_score,
    input  logic [NAME_W-1:0]         i_new_name,
    input  logic [RIDX_W-1:0]         i_read_index,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [PLACED_W-1:0]       o_placed_at,
    output logic signed [SCORE_W-1:0] o_entry_score,
    output logic [NAME_W-1:0]         o_entry_name,
    output logic                      o_bad_index,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DAT_W-1:0]      i_cfg_data
);

    // Configuration registers.
    logic [ENTRIES_W-1:0] r_entries;
    logic [NLEN_W-1:0]    r_name_len;

    // Output register.
    logic                      r_out_valid;
    logic [PLACED_W-1:0]       r_placed;
    logic signed [SCORE_W-1:0] r_score;
    logic [NAME_W-1:0]         r_name;
    logic                      r_bad;

    logic                      w_accept;
    t_mode                     w_mode;
    logic [CNT_W-1:0]          w_count;
    t_bcast                    w_bcast;
    logic                      w_commit;
    logic [CNT_W-1:0]          w_pos;
    logic [IDX_W-1:0]          w_rd_addr;
    logic                      w_idx_ok;

    logic                      w_found [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0]    w_here;
    logic signed [SCORE_W-1:0] w_cell_score [TABLE_DEPTH];
    logic [NAME_W-1:0]         w_cell_name [TABLE_DEPTH];
    logic signed [SCORE_W-1:0] w_prev_score [TABLE_DEPTH];
    logic [NAME_W-1:0]         w_prev_name [TABLE_DEPTH];

    logic [PLACED_W-1:0]       n_placed;
    logic signed [SCORE_W-1:0] n_score;
    logic [NAME_W-1:0]         n_name;
    logic                      n_bad;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_mode      = t_mode'(i_mode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries  <= ENTRIES_W'(TABLE_DEPTH);
            r_name_len <= NLEN_W'(NAME_BYTES);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ENTRIES:  r_entries  <= i_cfg_data[ENTRIES_W-1:0];
                CFG_NAME_LEN: r_name_len <= i_cfg_data[NLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // The live count: zero behaves as one, anything above the table size as the size.
    always_comb begin
        if (r_entries == '0) begin
            w_count = CNT_W'(1);
        end else if (int'(r_entries) > TABLE_DEPTH) begin
            w_count = CNT_W'(TABLE_DEPTH);
        end else begin
            w_count = CNT_W'(r_entries);
        end
    end

    assign w_bcast.score = i_new_score;
    assign w_bcast.name  = i_new_name & name_mask(r_name_len);
    assign w_bcast.count = w_count;

    // The search runs down the row: the first live cell whose score is not above the
    // new one marks the insertion point, and every live cell below it takes its
    // neighbour's entry. With no such cell the insert is refused and nothing moves.
    assign w_found[0] = 1'b0;
    assign w_commit   = w_accept && (w_mode == MODE_INSERT) && w_found[TABLE_DEPTH];

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev_score[g] = '0;
            assign w_prev_name[g]  = '0;
        end else begin : g_link
            assign w_prev_score[g] = w_cell_score[g-1];
            assign w_prev_name[g]  = w_cell_name[g-1];
        end

        sktab_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cell_idx   (IDX_W'(g)),
            .i_bcast      (w_bcast),
            .i_commit     (w_commit),
            .i_found      (w_found[g]),
            .i_prev_score (w_prev_score[g]),
            .i_prev_name  (w_prev_name[g]),
            .o_found      (w_found[g+1]),
            .o_here       (w_here[g]),
            .o_score      (w_cell_score[g]),
            .o_name       (w_cell_name[g])
        );
    end

    // At most one cell flags itself as the insertion point, so an OR of the flagged
    // positions gives the rank. A refused insert reports the live count.
    always_comb begin
        w_pos = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (w_here[k]) begin
                w_pos = w_pos | CNT_W'(k);
            end
        end
        if (!w_found[TABLE_DEPTH]) begin
            w_pos = w_count;
        end
    end

    // Reads use a single selected position: the requested index or the lowest live entry.
    assign w_idx_ok = {{(32-RIDX_W){1'b0}}, i_read_index} < 32'(w_count);

    always_comb begin
        if (w_mode == MODE_READ_IDX) begin
            w_rd_addr = IDX_W'(i_read_index);
        end else begin
            w_rd_addr = IDX_W'(w_count - CNT_W'(1));
        end
    end

    always_comb begin
        n_placed = '0;
        n_score  = '0;
        n_name   = '0;
        n_bad    = 1'b0;
        case (w_mode)
            MODE_INSERT: begin
                n_placed = PLACED_W'(w_pos);
            end
            MODE_READ_IDX: begin
                if (w_idx_ok) begin
                    n_score = w_cell_score[w_rd_addr];
                    n_name  = w_cell_name[w_rd_addr];
                end else begin
                    n_bad = 1'b1;
                end
            end
            MODE_READ_LOW: begin
                n_score = w_cell_score[w_rd_addr];
                n_name  = w_cell_name[w_rd_addr];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_placed <= n_placed;
            r_score  <= n_score;
            r_name   <= n_name;
            r_bad    <= n_bad;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_placed_at   = r_placed;
    assign o_entry_score = r_score;
    assign o_entry_name  = r_name;
    assign o_bad_index   = r_bad;

`ifndef SYNTH
    // Only one cell may claim the insertion point.
    a_single_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_here))
        else $error("more than one insertion point in the row");

    // A placed score lands at the rank that is reported for it.
    a_placed_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (w_cell_score[r_placed[IDX_W-1:0]] == $past(i_new_score)))
        else $error("inserted score not found at its reported rank");

    // A reported rank never lies beyond the live count.
    a_placed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_mode == MODE_INSERT)) |-> (w_pos <= w_count))
        else $error("insertion rank beyond the live count");
`endif

endmodule

/* bench/sorted_top_k_score_table_checker.sv */
`timescale 1ns / 1ps

// Keeps its own copy of the ranked table and of both registers, works out the result
// word for every accepted input word and compares the returned words in order.
module sorted_top_k_score_table_checker
    import sktab_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [1:0]                i_mode,
    input  logic signed [SCORE_W-1:0] i_new_score,
    input  logic [NAME_W-1:0]         i_new_name,
    input  logic [RIDX_W-1:0]         i_read_index,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [PLACED_W-1:0]       i_placed_at,
    input  logic signed [SCORE_W-1:0] i_entry_score,
    input  logic [NAME_W-1:0]         i_entry_name,
    input  logic                      i_bad_index,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DAT_W-1:0]      i_cfg_data,
    output int                        o_mismatches,
    output int                        o_outstanding
);

    typedef struct packed {
        logic [PLACED_W-1:0]       placed;
        logic signed [SCORE_W-1:0] score;
        logic [NAME_W-1:0]         name;
        logic                      bad;
    } t_rank_result;

    logic signed [SCORE_W-1:0] held_score [TABLE_DEPTH];
    logic [NAME_W-1:0]         held_name  [TABLE_DEPTH];
    logic [ENTRIES_W-1:0]      entries_reg;
    logic [NLEN_W-1:0]         name_len_reg;
    t_rank_result              pending_results [$];
    int                        mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // Applies one word to the copy of the table and returns the word it should produce.
    function automatic t_rank_result step_rank_table(
        input t_mode                     mode,
        input logic signed [SCORE_W-1:0] score,
        input logic [NAME_W-1:0]         name,
        input logic [RIDX_W-1:0]         index
    );
        t_rank_result      res;
        int                live;
        int                slot;
        int                kept_bytes;
        logic [NAME_W-1:0] keep;
        res  = '0;
        live = (entries_reg == 0) ? 1 :
               (entries_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_reg);
        case (mode)
            MODE_INSERT: begin
                slot = 0;
                while (slot < live && held_score[slot] > score) slot++;
                if (slot < live) begin
                    kept_bytes = (name_len_reg > NAME_BYTES) ? NAME_BYTES : int'(name_len_reg);
                    keep = (kept_bytes >= 8) ? '1 : ((64'd1 << (8 * kept_bytes)) - 64'd1);
                    for (int k = live - 1; k > slot; k--) begin
                        held_score[k] = held_score[k-1];
                        held_name[k]  = held_name[k-1];
                    end
                    held_score[slot] = score;
                    held_name[slot]  = name & keep;
                end
                // A refused insert reports the live entry count.
                res.placed = PLACED_W'(slot);
            end
            MODE_READ_IDX: begin
                if (int'(index) < live) begin
                    res.score = held_score[index];
                    res.name  = held_name[index];
                end else begin
                    res.bad = 1'b1;
                end
            end
            MODE_READ_LOW: begin
                res.score = held_score[live-1];
                res.name  = held_name[live-1];
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rank_result seen;
        t_rank_result wanted;
        if (!i_rst_n) begin
            for (int e = 0; e < TABLE_DEPTH; e++) begin
                held_score[e] = '0;
                held_name[e]  = '0;
            end
            entries_reg  = ENTRIES_W'(16);
            name_len_reg = NLEN_W'(8);
            pending_results.delete();
        end else begin
            // Retire the returned word before queueing the new one: a word cannot
            // come back in the cycle it was taken.
            if (i_out_valid && !i_out_stall) begin
                seen = '{i_placed_at, i_entry_score, i_entry_name, i_bad_index};
                if (pending_results.size() == 0) begin
                    $error("result word with nothing awaited: placed_at %0d score %0d",
                           seen.placed, seen.score);
                    mismatch_count++;
                end else begin
                    wanted = pending_results.pop_front();
                    if (seen.placed != wanted.placed) begin
                        $error("placed_at: expected %0d, got %0d", wanted.placed, seen.placed);
                        mismatch_count++;
                    end
                    if (seen.score != wanted.score) begin
                        $error("entry_score: expected %0d, got %0d", wanted.score, seen.score);
                        mismatch_count++;
                    end
                    if (seen.name != wanted.name) begin
                        $error("entry_name: expected %h, got %h", wanted.name, seen.name);
                        mismatch_count++;
                    end
                    if (seen.bad != wanted.bad) begin
                        $error("bad_index: expected %0d, got %0d", wanted.bad, seen.bad);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_ENTRIES) begin
                    entries_reg = i_cfg_data[ENTRIES_W-1:0];
                end else if (i_cfg_index == CFG_NAME_LEN) begin
                    name_len_reg = i_cfg_data[NLEN_W-1:0];
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(step_rank_table(t_mode'(i_mode), i_new_score,
                                                          i_new_name, i_read_index));
            end
        end
        o_outstanding = pending_results.size();
    end

endmodule

/* bench/sorted_top_k_score_table_tb.sv */
`timescale 1ns / 1ps

// Drives the ranked score table through a short directed opening and then eight random
// phases, each under its own pair of register settings. The checker beside the block
// holds the expected behaviour; this module only makes words, idles both sides and
// gives the verdict.
module sorted_top_k_score_table_tb;
    import sktab_pkg::*;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    t_mode                     in_mode;
    logic signed [SCORE_W-1:0] in_score;
    logic [NAME_W-1:0]         in_name;
    logic [RIDX_W-1:0]         in_index;
    logic                      out_valid;
    logic                      out_stall;
    logic [PLACED_W-1:0]       placed_at;
    logic signed [SCORE_W-1:0] entry_score;
    logic [NAME_W-1:0]         entry_name;
    logic                      bad_index;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DAT_W-1:0]      cfg_data;
    int                        mismatches;
    int                        outstanding;

    // When set, neither side inserts idle cycles, so words flow back to back.
    bit no_idle = 1'b0;

    int words_sent    = 0;
    int inserts_sent  = 0;
    int index_reads   = 0;
    int lowest_reads  = 0;
    int unused_words  = 0;
    int reg_writes    = 0;

    logic signed [SCORE_W-1:0] recent_scores [$];

    sorted_top_k_score_table uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_mode        (in_mode),
        .i_new_score   (in_score),
        .i_new_name    (in_name),
        .i_read_index  (in_index),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_placed_at   (placed_at),
        .o_entry_score (entry_score),
        .o_entry_name  (entry_name),
        .o_bad_index   (bad_index),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    sorted_top_k_score_table_checker rank_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_mode        (in_mode),
        .i_new_score   (in_score),
        .i_new_name    (in_name),
        .i_read_index  (in_index),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_placed_at   (placed_at),
        .i_entry_score (entry_score),
        .i_entry_name  (entry_name),
        .i_bad_index   (bad_index),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Overall time limit, several times the slowest legal run.
    initial begin
        #2_000_000;
        $display("Run stopped by the time limit with %0d result words still awaited",
                 outstanding);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // The output side: before each result word it stalls for a random number of cycles,
    // then lets words through until one is taken. Stalls thus land on every phase of
    // the block's work, including cycles with no word waiting at all.
    initial begin
        int hold;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            hold = no_idle ? 0 : $urandom_range(0, 7);
            if (hold > 0) begin
                out_stall = 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic logic [NAME_W-1:0] random_name();
        return {$urandom, $urandom};
    endfunction

    // Presents one word after a random gap and holds it until the block takes it.
    // With no gap the valid simply stays high and only the payload moves on.
    task automatic send_word(input t_mode mode, input logic signed [SCORE_W-1:0] score,
                             input logic [NAME_W-1:0] name, input logic [RIDX_W-1:0] index);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_mode  = mode;
        in_score = score;
        in_name  = name;
        in_index = index;
        do @(posedge clk); while (in_stall);
        words_sent++;
        case (mode)
            MODE_INSERT:   inserts_sent++;
            MODE_READ_IDX: index_reads++;
            MODE_READ_LOW: lowest_reads++;
            default:       unused_words++;
        endcase
    endtask

    // Stops sending and waits until every awaited result word has come back. Every
    // word yields exactly one result, so an empty queue means the block is idle.
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        reg_writes++;
    endtask

    initial begin
        logic [CFG_DAT_W-1:0]      count;
        logic [CFG_DAT_W-1:0]      nlen;
        logic signed [SCORE_W-1:0] score;
        t_mode                     mode;
        int                        pick;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_mode   = MODE_INSERT;
        in_score  = '0;
        in_name   = '0;
        in_index  = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ENTRIES;
        cfg_data  = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed opening under the reset settings: sixteen entries, full names.
        // Reads of the freshly cleared table must give zero scores and empty names.
        send_word(MODE_READ_LOW, $urandom, random_name(), 4'd0);
        send_word(MODE_READ_IDX, $urandom, random_name(), 4'd15);
        // A zero score ties with the cleared entries and goes to the top.
        send_word(MODE_INSERT, 32'sd0, '1, 4'd0);
        send_word(MODE_INSERT, 32'sh7FFF_FFFF, 64'h0048_4746_4544_4342, 4'd7);
        // Negative scores lose to every zero in the table and are refused.
        send_word(MODE_INSERT, 32'sh8000_0000, random_name(), 4'd0);
        send_word(MODE_INSERT, -32'sd1, random_name(), 4'd0);
        // Another zero: the newest of equal scores ranks above the older one.
        send_word(MODE_INSERT, 32'sd0, 64'h5A5A_5A5A_A5A5_A5A5, 4'd0);
        send_word(MODE_INSERT, 32'sd5, random_name(), 4'd0);
        send_word(MODE_NONE, $urandom, random_name(), 4'($urandom));
        send_word(MODE_READ_IDX, $urandom, random_name(), 4'd1);
        send_word(MODE_READ_IDX, $urandom, random_name(), 4'd0);

        // An entry count of zero behaves as one, and a name length of zero keeps no bytes.
        drain_results();
        write_register(CFG_ENTRIES, 5'd0);
        write_register(CFG_NAME_LEN, 5'd0);
        send_word(MODE_INSERT, 32'sh8000_0000, random_name(), 4'd0);
        send_word(MODE_INSERT, 32'sh7FFF_FFFF, '1, 4'd0);
        send_word(MODE_READ_IDX, $urandom, random_name(), 4'd1);
        send_word(MODE_READ_IDX, $urandom, random_name(), 4'd0);
        send_word(MODE_READ_LOW, $urandom, random_name(), 4'd9);

        // Oversized entry count clamps to the table size; a short name keeps three bytes.
        drain_results();
        write_register(CFG_ENTRIES, 5'd31);
        write_register(CFG_NAME_LEN, 5'd3);
        send_word(MODE_INSERT, 32'sd100, '1, 4'd0);
        send_word(MODE_READ_IDX, $urandom, random_name(), 4'd2);
        send_word(MODE_READ_IDX, $urandom, random_name(), 4'd15);

        // Four live entries; the name length has its top bit set and acts as full length.
        // The entries below rank four are kept and come back into view later.
        drain_results();
        write_register(CFG_ENTRIES, 5'd4);
        write_register(CFG_NAME_LEN, 5'h1F);
        send_word(MODE_READ_IDX, $urandom, random_name(), 4'd4);
        send_word(MODE_READ_IDX, $urandom, random_name(), 4'd3);
        send_word(MODE_INSERT, -32'sd1, random_name(), 4'd0);
        send_word(MODE_READ_LOW, $urandom, random_name(), 4'd0);

        // Random phases. Each starts with the block fully drained, which also serves as
        // the sender holding back until every result word has returned.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       count = 5'd16;
                1:       count = 5'd1;
                2:       count = 5'd0;
                3:       count = 5'd31;
                4:       count = 5'd2;
                default: count = 5'($urandom_range(3, 31));
            endcase
            if (phase % 3 == 0) begin
                nlen = 5'd8;
            end else if (phase == 1) begin
                nlen = 5'd0;
            end else begin
                nlen = 5'($urandom_range(0, 31));
            end
            drain_results();
            write_register(CFG_ENTRIES, count);
            write_register(CFG_NAME_LEN, nlen);

            for (int w = 0; w < 150; w++) begin
                // Roughly one stretch in four runs with no idling on either side.
                if (w % 25 == 0) begin
                    no_idle = ($urandom_range(0, 3) == 0);
                end
                pick = $urandom_range(0, 19);
                mode = (pick < 10) ? MODE_INSERT :
                       (pick < 15) ? MODE_READ_IDX :
                       (pick < 19) ? MODE_READ_LOW : MODE_NONE;
                // Scores near zero give many ties, full-range scores spread the ranks,
                // and scores close to recent inserts land in the middle of the table.
                case ($urandom_range(0, 9))
                    0, 1, 2: score = $urandom_range(0, 16) - 8;
                    3, 4, 5: score = $urandom;
                    6: begin
                        case ($urandom_range(0, 3))
                            0:       score = 32'sh7FFF_FFFF;
                            1:       score = 32'sh8000_0000;
                            2:       score = '0;
                            default: score = '1;
                        endcase
                    end
                    default: begin
                        if (recent_scores.size() == 0) begin
                            score = $urandom;
                        end else begin
                            score = recent_scores[$urandom_range(0, recent_scores.size() - 1)]
                                    + $urandom_range(0, 2) - 1;
                        end
                    end
                endcase
                send_word(mode, score, random_name(), 4'($urandom));
                if (mode == MODE_INSERT) begin
                    recent_scores.push_back(score);
                    if (recent_scores.size() > 16) begin
                        void'(recent_scores.pop_front());
                    end
                end
            end
        end

        no_idle = 1'b0;
        drain_results();
        repeat (4) @(negedge clk);

        $display("Sent %0d words: %0d inserts, %0d indexed reads, %0d lowest-entry reads, %0d unused-mode words.",
                 words_sent, inserts_sent, index_reads, lowest_reads, unused_words);
        $display("Made %0d register writes, entry counts from 0 to 31 and name lengths from 0 to 15.",
                 reg_writes);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
